FILE: rtl/core/assert_macros.svh
// assertion macros used by the rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/npcm_pkg.sv
// types, widths and palette rom for the nearest palette color match
// no dependencies
`default_nettype none

package npcm_pkg;

  localparam int ROM_COUNT = 41;
  localparam int INDEX_W   = 6;
  localparam int DIST_W    = 20;
  localparam int CHAN_W    = 8;
  localparam int SQ_W      = 16;

  localparam logic [INDEX_W-1:0] RESET_PALETTE_SIZE = 6'd40;
  localparam logic [DIST_W-1:0]  MAX_DIST           = 20'd585225;

  localparam logic [23:0] PALETTE_ROM [ROM_COUNT] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'hC0C0C0, 24'hFFFFFF,
    24'hFFFF00, 24'h800000, 24'hC0FF00, 24'h8B4513,
    24'h000080, 24'hF19CBB, 24'h008080, 24'hFFFFFF,
    24'h080808, 24'h121212, 24'h1C1C1C, 24'h262626,
    24'h303030, 24'h3A3A3A, 24'h444444, 24'h4E4E4E,
    24'h585858, 24'h626262, 24'h6C6C6C, 24'h767676,
    24'h808080, 24'h8A8A8A, 24'h949494, 24'h9E9E9E,
    24'hA8A8A8, 24'hB2B2B2, 24'hBCBCBC, 24'hC6C6C6,
    24'hD0D0D0, 24'hDADADA, 24'hE4E4E4, 24'hEEEEEE,
    24'hF8F8F8
  };

  typedef struct packed {
    logic               valid;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               blank;
    logic [INDEX_W-1:0] best_idx;
    logic [DIST_W-1:0]  best_dist;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/core/npcm_cell.sv
// one palette cell: distance to its rom color, running minimum, hand-off
// depends on npcm_pkg
`default_nettype none

module npcm_cell import npcm_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [INDEX_W-1:0] palette_size_i,
  input  wire token_t             token_i,
  output token_t                  token_o
);

  localparam logic [23:0]        COLOR  = PALETTE_ROM[CELL_INDEX];
  localparam logic [INDEX_W-1:0] MY_IDX = INDEX_W'(CELL_INDEX);
  localparam logic               FIRST  = (CELL_INDEX == 0);

  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r_d, sq_g_d, sq_b_d;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  token_t            mid_q;
  token_t            out_d, out_q;
  logic [DIST_W-1:0] dist_sum;
  logic              take;

  always_comb begin
    dr = (token_i.red > COLOR[23:16]) ? token_i.red - COLOR[23:16]
                                      : COLOR[23:16] - token_i.red;
    dg = (token_i.green > COLOR[15:8]) ? token_i.green - COLOR[15:8]
                                       : COLOR[15:8] - token_i.green;
    db = (token_i.blue > COLOR[7:0]) ? token_i.blue - COLOR[7:0]
                                     : COLOR[7:0] - token_i.blue;
    sq_r_d = {8'd0, dr} * {8'd0, dr};
    sq_g_d = {8'd0, dg} * {8'd0, dg};
    sq_b_d = {8'd0, db} * {8'd0, db};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
    end else begin
      mid_q <= token_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_r_d;
    sq_g_q <= sq_g_d;
    sq_b_q <= sq_b_d;
  end

  // 2*r^2 + 4*g^2 + 3*b^2
  always_comb begin
    dist_sum = {3'd0, sq_r_q, 1'b0} + {2'd0, sq_g_q, 2'b00}
             + {4'd0, sq_b_q} + {3'd0, sq_b_q, 1'b0};
    take = FIRST || ((MY_IDX < palette_size_i) && (dist_sum < mid_q.best_dist));
    out_d = mid_q;
    if (take) begin
      out_d.best_idx  = MY_IDX + INDEX_W'(1);
      out_d.best_dist = dist_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign token_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_palette_color_match_unit.sv
// top level: row of palette cells that a pixel walks through
// depends on npcm_pkg, npcm_cell and assert_macros.svh
//
// usage
//   a pixel (red_i, green_i, blue_i) is taken at a rising edge with start
//   high and busy low. busy stays low: the row of cells takes a new pixel
//   in every cycle, so throughput is one transaction per cycle.
//   each cell owns one palette entry and works on a pixel in registered
//   steps (squared channel differences, then weighted sum and compare
//   against the running best) before handing it on to the next cell.
//   the result (color_index_o, blank_o, best_distance_o) is shown for one
//   cycle with done_o high; the receiver cannot stall it, results come out
//   in the order the pixels went in.
//   cfg_we_i writes cfg_wdata_i into the palette size register; write it only
//   while no pixel is in the row. entries at or beyond that size are skipped,
//   a size of zero still searches entry one.
//   reset empties the row and sets the palette size to 40.
`default_nettype none
`include "assert_macros.svh"

module nearest_palette_color_match_unit import npcm_pkg::*; #(
  parameter int PALETTE_ENTRIES = 41
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CHAN_W-1:0]  red_i,
  input  wire logic [CHAN_W-1:0]  green_i,
  input  wire logic [CHAN_W-1:0]  blue_i,
  input  wire logic               cfg_we_i,
  input  wire logic [INDEX_W-1:0] cfg_wdata_i,
  output logic                    done_o,
  output logic [INDEX_W-1:0]      color_index_o,
  output logic                    blank_o,
  output logic [DIST_W-1:0]       best_distance_o
);

  localparam int CELLS   = (PALETTE_ENTRIES < ROM_COUNT) ? PALETTE_ENTRIES : ROM_COUNT;
  localparam int LATENCY = 2 * CELLS;

  logic [INDEX_W-1:0] palette_size_q;
  token_t             chain [CELLS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= RESET_PALETTE_SIZE;
    end else if (cfg_we_i) begin
      palette_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    chain[0].valid     = start && !busy;
    chain[0].red       = red_i;
    chain[0].green     = green_i;
    chain[0].blue      = blue_i;
    chain[0].blank     = (red_i == '1) && (green_i == '1) && (blue_i == '1);
    chain[0].best_idx  = '0;
    chain[0].best_dist = '0;
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .palette_size_i (palette_size_q),
      .token_i        (chain[g]),
      .token_o        (chain[g+1])
    );
  end

  assign done_o          = chain[CELLS].valid;
  assign color_index_o   = chain[CELLS].best_idx;
  assign blank_o         = chain[CELLS].blank;
  assign best_distance_o = chain[CELLS].best_dist;

  `ASSERT_PROP(a_latency, clk_i, rst_ni, (start && !busy) |-> ##LATENCY done_o)
  `ASSERT_PROP(a_index_range, clk_i, rst_ni,
    done_o |-> (color_index_o != '0) && (color_index_o <= INDEX_W'(CELLS)))
  `ASSERT_NEVER(a_dist_range, clk_i, rst_ni, done_o && (best_distance_o > MAX_DIST))
  `ASSERT_PROP(a_no_spurious, clk_i, rst_ni,
    done_o |-> $past(start && !busy, LATENCY))

endmodule

`default_nettype wire

FILE: verif/nearest_palette_color_match_unit_test.sv
// self-checking testbench for nearest_palette_color_match_unit
// depends on npcm_pkg and the unit; computes expected matches from its own
// copy of the palette and checks each result against the oldest pending pixel
`default_nettype none

module nearest_palette_color_match_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import npcm_pkg::*;

  localparam int PALETTE_DEPTH = 41;
  localparam int RESET_SIZE    = 40;
  localparam int PIPE_LATENCY  = 2 * PALETTE_DEPTH;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_REPORTS   = 50;

  localparam bit [23:0] BASE_COLORS [16] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'hC0C0C0, 24'hFFFFFF,
    24'hFFFF00, 24'h800000, 24'hC0FF00, 24'h8B4513,
    24'h000080, 24'hF19CBB, 24'h008080, 24'hFFFFFF
  };

  typedef struct {
    bit [INDEX_W-1:0] index;
    bit               blank;
    bit [DIST_W-1:0]  distance;
  } match_t;

  typedef struct {
    bit [CHAN_W-1:0] r;
    bit [CHAN_W-1:0] g;
    bit [CHAN_W-1:0] b;
  } pixel_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [CHAN_W-1:0]  red_i;
  logic [CHAN_W-1:0]  green_i;
  logic [CHAN_W-1:0]  blue_i;
  logic               cfg_we_i;
  logic [INDEX_W-1:0] cfg_wdata_i;
  logic               done_o;
  logic [INDEX_W-1:0] color_index_o;
  logic               blank_o;
  logic [DIST_W-1:0]  best_distance_o;

  match_t pending_matches[$];
  int     palette_size_now = RESET_SIZE;
  int     mismatch_count   = 0;
  int     cycle_count      = 0;
  bit     steady_flow      = 1'b0;

  nearest_palette_color_match_unit #(
    .PALETTE_ENTRIES(PALETTE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .color_index_o  (color_index_o),
    .blank_o        (blank_o),
    .best_distance_o(best_distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit [23:0] palette_color(int idx);
    bit [7:0] level;
    if (idx < 16) begin
      return BASE_COLORS[idx];
    end
    level = 8'(8 + 10 * (idx - 16));
    return {level, level, level};
  endfunction

  // weighted nearest search over the active part of the palette
  function automatic match_t nearest_match(pixel_t px, int size);
    match_t    m;
    int        span;
    int        best;
    int        best_d;
    int        d;
    int        dr;
    int        dg;
    int        db;
    bit [23:0] c;
    span = size;
    if (span < 1) span = 1;
    if (span > PALETTE_DEPTH) span = PALETTE_DEPTH;
    best   = 0;
    best_d = 32'h7FFF_FFFF;
    for (int i = 0; i < span; i++) begin
      c  = palette_color(i);
      dr = int'(px.r) - int'(c[23:16]);
      dg = int'(px.g) - int'(c[15:8]);
      db = int'(px.b) - int'(c[7:0]);
      d  = 2 * dr * dr + 4 * dg * dg + 3 * db * db;
      if (d < best_d) begin
        best_d = d;
        best   = i;
      end
    end
    m.index    = INDEX_W'(best + 1);
    m.blank    = (px.r == 8'hFF) && (px.g == 8'hFF) && (px.b == 8'hFF);
    m.distance = DIST_W'(best_d);
    return m;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t    px;
    int        kind;
    int        ch [3];
    bit [23:0] c;
    kind = $urandom_range(99);
    if (kind < 40) begin
      px.r = 8'($urandom);
      px.g = 8'($urandom);
      px.b = 8'($urandom);
    end else if (kind < 75) begin
      // jitter around one palette entry
      c     = palette_color($urandom_range(PALETTE_DEPTH - 1));
      ch[0] = int'(c[23:16]) + int'($urandom_range(12)) - 6;
      ch[1] = int'(c[15:8]) + int'($urandom_range(12)) - 6;
      ch[2] = int'(c[7:0]) + int'($urandom_range(12)) - 6;
      foreach (ch[k]) begin
        if (ch[k] < 0) ch[k] = 0;
        if (ch[k] > 255) ch[k] = 255;
      end
      px.r = 8'(ch[0]);
      px.g = 8'(ch[1]);
      px.b = 8'(ch[2]);
    end else if (kind < 90) begin
      px.r = 8'($urandom);
      px.g = px.r;
      px.b = px.r;
    end else begin
      px.r = $urandom_range(1) ? 8'hFF : 8'h00;
      px.g = $urandom_range(1) ? 8'hFF : 8'h00;
      px.b = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    pixel_t px;
    px.r = r;
    px.g = g;
    px.b = b;
    if (!start) start <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_matches.push_back(nearest_match(px, palette_size_now));
    @(negedge clk_i);
    if (!steady_flow) begin
      while ($urandom_range(99) < 26) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_for_results();
    if (start) start <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_palette_size(int size);
    wait_for_results();
    cfg_wdata_i <= INDEX_W'(size);
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    palette_size_now = size & 6'h3F;
  endtask

  always @(posedge clk_i) begin : check_results
    match_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("result with no pixel pending");
      end else begin
        want = pending_matches.pop_front();
        if (color_index_o !== want.index)
          report_mismatch($sformatf("color_index got %0d want %0d", color_index_o,
                                    want.index));
        if (blank_o !== want.blank)
          report_mismatch($sformatf("blank got %b want %b", blank_o, want.blank));
        if (best_distance_o !== want.distance)
          report_mismatch($sformatf("best_distance got %0d want %0d", best_distance_o,
                                    want.distance));
      end
    end
  end

  // default size of 40 leaves the last gray out of the search
  task automatic test_reset_palette();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFE);
    send_pixel(8'hFE, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'hFE, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'hF8, 8'hF8, 8'hF8);
    send_pixel(8'h8B, 8'h45, 8'h13);
    send_pixel(8'hF1, 8'h9C, 8'hBB);
    send_pixel(8'hC0, 8'hFF, 8'h00);
    send_pixel(8'h0D, 8'h0D, 8'h0D);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
  endtask

  // size zero acts as one, sizes past the rom clamp, duplicates lose ties
  task automatic test_size_extremes();
    set_palette_size(0);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h0A, 8'h14, 8'h1E);
    set_palette_size(1);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    set_palette_size(63);
    send_pixel(8'hF8, 8'hF8, 8'hF8);
    send_pixel(8'hFA, 8'hFA, 8'hFA);
    set_palette_size(41);
    send_pixel(8'hF3, 8'hF3, 8'hF3);
    set_palette_size(9);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    set_palette_size(16);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_random_sizes();
    int     size;
    pixel_t px;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: size = 1;
        1: size = 41;
        2: size = 63;
        3: size = 2;
        default: size = $urandom_range(63);
      endcase
      set_palette_size(size);
      for (int n = 0; n < 140; n++) begin
        // sender holds off until the row is empty
        if (phase == 4 && n == 70) wait_for_results();
        px = random_pixel();
        send_pixel(px.r, px.g, px.b);
      end
    end
  endtask

  task automatic test_back_to_back();
    pixel_t px;
    set_palette_size(41);
    steady_flow = 1'b1;
    for (int n = 0; n < 350; n++) begin
      px = random_pixel();
      send_pixel(px.r, px.g, px.b);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_palette();
    test_size_extremes();
    test_random_sizes();
    test_back_to_back();

    wait_for_results();
    repeat (PIPE_LATENCY + 20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/npcm_pkg.sv
rtl/core/npcm_cell.sv
rtl/core/nearest_palette_color_match_unit.sv
verif/nearest_palette_color_match_unit_test.sv
